FILE: src/bmh_pkg.sv
package bmh_pkg;

  // Heap geometry
  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = SLOT_W + 2;
  localparam int KEY_W    = 32;
  localparam int INDEX_W  = 4;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_CHANGE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST_EV,
    S_UP_RD,
    S_UP_EV,
    S_DEL_RD,
    S_DEL_EV,
    S_LAST_RD,
    S_LAST_EV,
    S_DN_RD,
    S_DN_EV,
    S_DONE
  } state_t;

endpackage

FILE: src/bmh_req_if.sv
interface bmh_req_if;
  logic                          valid;
  logic                          ready;
  bmh_pkg::cmd_t                 cmd;
  bmh_pkg::key_t                 key_value;
  logic [bmh_pkg::INDEX_W-1:0]   slot_index;

  modport source (output valid, output cmd, output key_value, output slot_index,
                  input ready);
  modport sink   (input valid, input cmd, input key_value, input slot_index,
                  output ready);
endinterface

FILE: src/bmh_rsp_if.sv
interface bmh_rsp_if;
  logic                          valid;
  logic                          ready;
  bmh_pkg::key_t                 result_key;
  bmh_pkg::status_t              status;
  logic [bmh_pkg::COUNT_W-1:0]   occupancy;

  modport source (output valid, output result_key, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input result_key, input status, input occupancy,
                  output ready);
endinterface

FILE: src/binary_max_heap_priority_queue_unit.sv
// Binary max-heap priority queue of signed 32-bit keys, held in one 16-entry
// synchronous RAM (one write port, two registered read ports). Commands are
// taken one at a time: insert, extract max, delete at slot, and change key at
// slot; each gives exactly one response with the removed key (zero when none
// is removed), a status code and the occupancy after the command. Each heap
// level visited takes a RAM read, then a compare and write back; rejected
// commands (full, empty, slot beyond count) go straight to the response. The
// moving key is kept in a register and written once at the end of the sift,
// so each level needs only one RAM write. A new command is taken while the
// previous response still waits on the output register. No clearing pass
// follows reset.
module binary_max_heap_priority_queue_unit (
  input  logic      clk,
  input  logic      rst,
  bmh_req_if.sink   req,
  bmh_rsp_if.source rsp
);

  localparam int SW = bmh_pkg::SLOT_W;
  localparam int CW = bmh_pkg::COUNT_W;
  localparam int HW = bmh_pkg::CHILD_W;

  // Heap RAM
  bmh_pkg::key_t heap_mem [bmh_pkg::CAPACITY];
  bmh_pkg::key_t rd_a;
  bmh_pkg::key_t rd_b;
  logic [SW-1:0] rd_addr_a;
  logic [SW-1:0] rd_addr_b;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  bmh_pkg::key_t wr_data;

  // Control and datapath registers
  bmh_pkg::state_t  state, state_next;
  bmh_pkg::cmd_t    op, op_next;
  logic [SW-1:0]    pos, pos_next;
  bmh_pkg::key_t    carry, carry_next;
  bmh_pkg::key_t    res_key, res_key_next;
  bmh_pkg::status_t res_status, res_status_next;
  logic [CW-1:0]    count, count_next;

  // Output register
  logic             o_valid, o_valid_next;
  bmh_pkg::key_t    o_key, o_key_next;
  bmh_pkg::status_t o_status, o_status_next;
  logic [CW-1:0]    o_occ, o_occ_next;

  // Index arithmetic
  logic [SW-1:0] parent_pos;
  logic [HW-1:0] lt_idx;
  logic [HW-1:0] rt_idx;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] req_slot;
  logic          lt_ok;
  logic          rt_ok;
  logic          go_l;
  logic          go_r;
  bmh_pkg::key_t big_val;

  assign parent_pos = (pos - SW'(1)) >> 1;
  assign lt_idx     = {1'b0, pos, 1'b1};
  assign rt_idx     = lt_idx + HW'(1);
  assign last_idx   = count - CW'(1);
  assign req_slot   = CW'(req.slot_index);
  assign lt_ok      = lt_idx < HW'(count);
  assign rt_ok      = rt_idx < HW'(count);

  // Larger child selection, left child wins a tie
  assign go_l    = lt_ok && (rd_a > carry);
  assign big_val = go_l ? rd_a : carry;
  assign go_r    = rt_ok && (rd_b > big_val);

  assign req.ready  = (state == bmh_pkg::S_IDLE);
  assign rsp.valid      = o_valid;
  assign rsp.result_key = o_key;
  assign rsp.status     = o_status;
  assign rsp.occupancy  = o_occ;

  // RAM: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a <= heap_mem[rd_addr_a];
    rd_b <= heap_mem[rd_addr_b];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bmh_pkg::S_IDLE;
      count   <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      o_valid <= o_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op         <= op_next;
    pos        <= pos_next;
    carry      <= carry_next;
    res_key    <= res_key_next;
    res_status <= res_status_next;
    o_key      <= o_key_next;
    o_status   <= o_status_next;
    o_occ      <= o_occ_next;
  end

  // Next state and datapath control
  always_comb begin
    state_next      = state;
    op_next         = op;
    pos_next        = pos;
    carry_next      = carry;
    res_key_next    = res_key;
    res_status_next = res_status;
    count_next      = count;
    o_valid_next    = o_valid && !rsp.ready;
    o_key_next      = o_key;
    o_status_next   = o_status;
    o_occ_next      = o_occ;
    rd_addr_a       = pos;
    rd_addr_b       = pos;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = carry;

    case (state)
      bmh_pkg::S_IDLE: begin
        if (req.valid) begin
          op_next         = req.cmd;
          carry_next      = req.key_value;
          pos_next        = SW'(req.slot_index);
          res_key_next    = '0;
          res_status_next = bmh_pkg::ST_OK;
          rd_addr_a       = SW'(req.slot_index);
          if (req.cmd == bmh_pkg::CMD_INSERT) begin
            if (count >= CW'(bmh_pkg::CAPACITY)) begin
              res_status_next = bmh_pkg::ST_FULL;
              state_next      = bmh_pkg::S_DONE;
            end else begin
              pos_next   = count[SW-1:0];
              count_next = count + CW'(1);
              state_next = bmh_pkg::S_UP_RD;
            end
          end else if (count == '0) begin
            res_status_next = bmh_pkg::ST_EMPTY;
            state_next      = bmh_pkg::S_DONE;
          end else if (req.cmd == bmh_pkg::CMD_EXTRACT) begin
            rd_addr_a  = '0;
            rd_addr_b  = last_idx[SW-1:0];
            count_next = last_idx;
            state_next = bmh_pkg::S_FIRST_EV;
          end else if (req_slot >= count) begin
            res_status_next = bmh_pkg::ST_RANGE;
            state_next      = bmh_pkg::S_DONE;
          end else begin
            state_next = bmh_pkg::S_FIRST_EV;
          end
        end
      end

      bmh_pkg::S_FIRST_EV: begin
        case (op)
          bmh_pkg::CMD_EXTRACT: begin
            res_key_next = rd_a;
            carry_next   = rd_b;
            pos_next     = '0;
            state_next   = bmh_pkg::S_DN_RD;
          end
          bmh_pkg::CMD_DELETE: begin
            res_key_next = rd_a;
            state_next   = (pos == '0) ? bmh_pkg::S_LAST_RD : bmh_pkg::S_DEL_RD;
          end
          default: begin
            // change key: direction set by old versus new key
            state_next = (rd_a < carry) ? bmh_pkg::S_UP_RD : bmh_pkg::S_DN_RD;
          end
        endcase
      end

      // Sift up: hole at pos, moving key in carry
      bmh_pkg::S_UP_RD: begin
        rd_addr_a = parent_pos;
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = bmh_pkg::S_DONE;
        end else begin
          state_next = bmh_pkg::S_UP_EV;
        end
      end

      bmh_pkg::S_UP_EV: begin
        wr_en = 1'b1;
        if (rd_a < carry) begin
          wr_data    = rd_a;
          pos_next   = parent_pos;
          state_next = bmh_pkg::S_UP_RD;
        end else begin
          state_next = bmh_pkg::S_DONE;
        end
      end

      // Delete: shift the path to the root down one level
      bmh_pkg::S_DEL_RD: begin
        rd_addr_a  = parent_pos;
        state_next = bmh_pkg::S_DEL_EV;
      end

      bmh_pkg::S_DEL_EV: begin
        wr_en      = 1'b1;
        wr_data    = rd_a;
        pos_next   = parent_pos;
        state_next = (parent_pos == '0) ? bmh_pkg::S_LAST_RD : bmh_pkg::S_DEL_RD;
      end

      bmh_pkg::S_LAST_RD: begin
        rd_addr_a  = last_idx[SW-1:0];
        count_next = last_idx;
        state_next = bmh_pkg::S_LAST_EV;
      end

      bmh_pkg::S_LAST_EV: begin
        carry_next = rd_a;
        pos_next   = '0;
        state_next = bmh_pkg::S_DN_RD;
      end

      // Sift down: read both children
      bmh_pkg::S_DN_RD: begin
        rd_addr_a  = lt_idx[SW-1:0];
        rd_addr_b  = rt_idx[SW-1:0];
        state_next = bmh_pkg::S_DN_EV;
      end

      bmh_pkg::S_DN_EV: begin
        wr_en = 1'b1;
        if (go_r) begin
          wr_data    = rd_b;
          pos_next   = rt_idx[SW-1:0];
          state_next = bmh_pkg::S_DN_RD;
        end else if (go_l) begin
          wr_data    = rd_a;
          pos_next   = lt_idx[SW-1:0];
          state_next = bmh_pkg::S_DN_RD;
        end else begin
          state_next = bmh_pkg::S_DONE;
        end
      end

      // Hand the response to the output register once it is free
      bmh_pkg::S_DONE: begin
        if (!o_valid || rsp.ready) begin
          o_valid_next  = 1'b1;
          o_key_next    = res_key;
          o_status_next = res_status;
          o_occ_next    = count;
          state_next    = bmh_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bmh_pkg::S_IDLE;
      end
    endcase
  end

endmodule
